/* design/glsc_pkg.sv */
// shared types, constants and helpers for the line segment clip unit
`default_nettype none
package glsc_pkg;

  localparam int CoordW       = 32;
  localparam int DiffW        = 33;
  localparam int CrossW       = 64;
  localparam int DenW         = 64;
  localparam int QuoW         = 63;
  localparam int DistW        = 31;
  localparam int RegAddrW     = 5;
  localparam int FifoDepthDef = 8;
  localparam int FrontStages  = 6;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_BASE_X  = 3'd0,
    REG_BASE_Y  = 3'd1,
    REG_DIR_X   = 3'd2,
    REG_DIR_Y   = 3'd3,
    REG_NUDGE_X = 3'd4,
    REG_NUDGE_Y = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [CoordW-1:0] base_x;
    logic signed [CoordW-1:0] base_y;
    logic signed [CoordW-1:0] dir_x;
    logic signed [CoordW-1:0] dir_y;
    logic signed [CoordW-1:0] nudge_x;
    logic signed [CoordW-1:0] nudge_y;
  } cfg_t;

  // per-item status that travels along the back end
  typedef struct packed {
    logic            hit;
    logic            start_side;
    logic            end_side;
    logic            den_neg;
    logic [DenW-1:0] den;
  } info_t;

  // classified segment handed from front to back
  typedef struct packed {
    info_t                   info;
    logic signed [DiffW-1:0] vdx;
    logic signed [DiffW-1:0] vdy;
    logic signed [DiffW-1:0] dvx;
    logic signed [DiffW-1:0] dvy;
  } job_t;

  // saturate a signed value to 32 bits
  function automatic logic signed [CoordW-1:0] sat32(input logic signed [43:0] v);
    logic signed [43:0] hi;
    logic signed [43:0] lo;
    hi = 44'sh7FFF_FFFF;
    lo = -44'sh8000_0000;
    if (v > hi) return CoordW'(hi);
    else if (v < lo) return CoordW'(lo);
    else return CoordW'(v);
  endfunction

endpackage
`default_nettype wire

/* design/glsc_if.sv */
// segment and result channel interfaces
`default_nettype none
interface glsc_seg_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  modport source(output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink(input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface glsc_res_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] isect_x;
  logic signed [31:0] isect_y;
  logic               start_side;
  logic               end_side;
  logic [30:0]        distance;
  modport source(output valid, hit, isect_x, isect_y, start_side, end_side, distance,
                 input ready);
  modport sink(input valid, hit, isect_x, isect_y, start_side, end_side, distance,
               output ready);
endinterface
`default_nettype wire

/* design/glsc_cfg.sv */
// configuration registers behind the apb-style port
`default_nettype none
module glsc_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [glsc_pkg::RegAddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output glsc_pkg::cfg_t               cfg
);
  import glsc_pkg::*;

  logic     wr;
  reg_idx_t idx;

  // clamp a direction component to plus or minus one
  function automatic logic signed [31:0] clamp_dir(input logic signed [31:0] v);
    if (v > 32'sh4000_0000) return 32'sh4000_0000;
    else if (v < -32'sh4000_0000) return -32'sh4000_0000;
    else return v;
  endfunction

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[RegAddrW-1:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_x  <= '0;
      cfg.base_y  <= '0;
      cfg.dir_x   <= 32'sh4000_0000;
      cfg.dir_y   <= '0;
      cfg.nudge_x <= '0;
      cfg.nudge_y <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_BASE_X:  cfg.base_x  <= pwdata;
        REG_BASE_Y:  cfg.base_y  <= pwdata;
        REG_DIR_X:   cfg.dir_x   <= clamp_dir(pwdata);
        REG_DIR_Y:   cfg.dir_y   <= clamp_dir(pwdata);
        REG_NUDGE_X: cfg.nudge_x <= pwdata;
        REG_NUDGE_Y: cfg.nudge_y <= pwdata;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_BASE_X:  prdata = cfg.base_x;
      REG_BASE_Y:  prdata = cfg.base_y;
      REG_DIR_X:   prdata = cfg.dir_x;
      REG_DIR_Y:   prdata = cfg.dir_y;
      REG_NUDGE_X: prdata = cfg.nudge_x;
      REG_NUDGE_Y: prdata = cfg.nudge_y;
      default:     prdata = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_dir_x_range: assert property (@(posedge clk) disable iff (rst)
    (cfg.dir_x <= 32'sh4000_0000) && (cfg.dir_x >= -32'sh4000_0000))
    else $error("dir_x out of range");
  a_dir_y_range: assert property (@(posedge clk) disable iff (rst)
    (cfg.dir_y <= 32'sh4000_0000) && (cfg.dir_y >= -32'sh4000_0000))
    else $error("dir_y out of range");
`endif

endmodule
`default_nettype wire

/* design/glsc_front.sv */
// front end: side tests, on-line nudge and crossing classification
`default_nettype none
module glsc_front #(
  parameter int DEPTH = glsc_pkg::FifoDepthDef
) (
  input  logic                       clk,
  input  logic                       rst,
  glsc_seg_if.sink                   seg,
  input  glsc_pkg::cfg_t             cfg,
  input  logic [$clog2(DEPTH+1)-1:0] fifo_cnt,
  output logic                       job_valid,
  output glsc_pkg::job_t             job
);
  import glsc_pkg::*;

  localparam int CntW = $clog2(DEPTH+1);
  localparam int FlW  = $clog2(FrontStages+1);

  logic [FrontStages-1:0] v;
  logic [FlW-1:0]         inflight;
  logic [CntW:0]          used;
  logic                   accept;

  logic signed [CoordW-1:0] pt1 [8];
  logic signed [CoordW-1:0] pt2 [8];
  logic signed [DiffW-1:0]  df2 [8];
  logic signed [CoordW-1:0] pt3 [8];
  logic signed [64:0]       pa3 [4];
  logic signed [64:0]       pb3 [4];
  logic signed [CoordW-1:0] pt4 [8];
  logic signed [CrossW-1:0] cr4 [4];
  logic signed [CrossW-1:0] s5, e5;
  logic                     ss5, es5;
  logic signed [CoordW-1:0] nsx5, nsy5, nex5, ney5;
  logic [CrossW-1:0]        smag, emag;

  // credit: every item in flight has a queue slot waiting
  always_comb begin
    inflight = '0;
    for (int i = 0; i < FrontStages; i++) inflight = inflight + FlW'(v[i]);
  end
  assign used      = (CntW+1)'(fifo_cnt) + (CntW+1)'(inflight);
  assign seg.ready = used < (CntW+1)'(DEPTH);
  assign accept    = seg.valid && seg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[FrontStages-2:0], accept};
    end
  end

  assign smag = s5[CrossW-1] ? CrossW'(-s5) : CrossW'(s5);
  assign emag = e5[CrossW-1] ? CrossW'(-e5) : CrossW'(e5);

  always_ff @(posedge clk) begin
    // raw and nudged endpoints
    pt1[0] <= seg.start_x;
    pt1[1] <= seg.start_y;
    pt1[2] <= seg.end_x;
    pt1[3] <= seg.end_y;
    pt1[4] <= sat32(44'(seg.start_x) + 44'(cfg.nudge_x));
    pt1[5] <= sat32(44'(seg.start_y) + 44'(cfg.nudge_y));
    pt1[6] <= sat32(44'(seg.end_x) + 44'(cfg.nudge_x));
    pt1[7] <= sat32(44'(seg.end_y) + 44'(cfg.nudge_y));
    // offsets from the base point
    for (int k = 0; k < 8; k++) begin
      pt2[k] <= pt1[k];
      df2[k] <= DiffW'(pt1[k]) - DiffW'(k[0] ? cfg.base_y : cfg.base_x);
      pt3[k] <= pt2[k];
      pt4[k] <= pt3[k];
    end
    // cross product terms
    for (int p = 0; p < 4; p++) begin
      pa3[p] <= 65'(cfg.dir_x) * 65'(df2[2*p+1]);
      pb3[p] <= 65'(cfg.dir_y) * 65'(df2[2*p]);
      cr4[p] <= CrossW'(pa3[p] - pb3[p]);
    end
    // pick nudged endpoints where the raw one lies on the line
    s5   <= (cr4[0] == '0) ? cr4[2] : cr4[0];
    e5   <= (cr4[1] == '0) ? cr4[3] : cr4[1];
    ss5  <= cr4[0] > 0;
    es5  <= cr4[1] > 0;
    nsx5 <= (cr4[0] == '0) ? pt4[4] : pt4[0];
    nsy5 <= (cr4[0] == '0) ? pt4[5] : pt4[1];
    nex5 <= (cr4[1] == '0) ? pt4[6] : pt4[2];
    ney5 <= (cr4[1] == '0) ? pt4[7] : pt4[3];
    // crossing test and divider operands
    job.info.hit        <= (s5 != e5) && (((s5 <= 0) && (e5 >= 0)) || ((s5 >= 0) && (e5 <= 0)));
    job.info.start_side <= ss5;
    job.info.end_side   <= es5;
    job.info.den_neg    <= e5 < s5;
    job.info.den        <= smag + emag;
    job.vdx             <= DiffW'(nsx5) - DiffW'(cfg.base_x);
    job.vdy             <= DiffW'(nsy5) - DiffW'(cfg.base_y);
    job.dvx             <= DiffW'(nex5) - DiffW'(nsx5);
    job.dvy             <= DiffW'(ney5) - DiffW'(nsy5);
  end

  assign job_valid = v[FrontStages-1];

`ifndef SYNTHESIS
  a_credit: assert property (@(posedge clk) disable iff (rst)
    used <= (CntW+1)'(DEPTH))
    else $error("front credit exceeds queue depth");
`endif

endmodule
`default_nettype wire

/* design/glsc_fifo.sv */
// queue between front and back end
`default_nettype none
module glsc_fifo #(
  parameter int DEPTH = glsc_pkg::FifoDepthDef
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr,
  input  glsc_pkg::job_t             wdata,
  input  logic                       rd,
  output glsc_pkg::job_t             rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] cnt
);
  import glsc_pkg::*;

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH+1);

  job_t            mem [DEPTH];
  logic [PtrW-1:0] wp, rp;
  logic            full;

  assign empty = cnt == '0;
  assign full  = cnt == CntW'(DEPTH);
  assign rdata = mem[rp];

  // storage
  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= (wp == PtrW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (rd) rp <= (rp == PtrW'(DEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + CntW'(wr) - CntW'(rd);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(wr && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(rd && empty))
    else $error("queue read while empty");
`endif

endmodule
`default_nettype wire

/* design/glsc_back.sv */
// back end: numerator, pipelined divider and intersection point
`default_nettype none
module glsc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_empty,
  input  glsc_pkg::job_t job,
  output logic           pop,
  input  glsc_pkg::cfg_t cfg,
  glsc_res_if.source     res
);
  import glsc_pkg::*;

  localparam logic [QuoW-1:0] TClamp  = QuoW'(1) << 62;
  localparam logic [QuoW-1:0] DistMax = QuoW'(32'h7FFF_FFFF);
  localparam logic [63:0]     PtClamp = 64'd1 << 40;

  logic en;

  logic               b0_v;
  job_t               b0;
  logic               b1_v;
  info_t              b1_inf;
  logic signed [65:0] b1_p1, b1_p2;
  logic               b2_v;
  info_t              b2_inf;
  logic signed [66:0] b2_num;
  logic               b3_v;
  info_t              b3_inf;
  logic [66:0]        b3_mag;
  logic               b3_tneg;
  logic               b4_v;
  info_t              b4_inf;
  logic [96:0]        b4_m;
  logic               b4_tneg;

  logic             dv_v    [QuoW+1];
  info_t            dv_inf  [QuoW+1];
  logic             dv_ovf  [QuoW+1];
  logic             dv_tneg [QuoW+1];
  logic [63:0]      dv_rem  [QuoW+1];
  logic [QuoW-1:0]  dv_low  [QuoW+1];
  logic [QuoW-1:0]  dv_q    [QuoW+1];
  logic [64:0]      dv_t    [1:QuoW];
  logic             dv_ge   [1:QuoW];

  logic             a1_v;
  info_t            a1_inf;
  logic             a1_tneg;
  logic [QuoW-1:0]  a1_tmag;
  logic [DistW-1:0] a1_dist;
  logic             a2_v;
  info_t            a2_inf;
  logic [DistW-1:0] a2_dist;
  logic             a2_xneg, a2_yneg;
  logic [62:0]      a2_xl, a2_yl;
  logic [61:0]      a2_xh, a2_yh;
  logic             a3_v;
  info_t            a3_inf;
  logic [DistW-1:0] a3_dist;
  logic             a3_xneg, a3_yneg;
  logic [93:0]      a3_px, a3_py;

  logic             o_v;
  logic             o_hit, o_ss, o_es;
  logic signed [31:0] o_x, o_y;
  logic [DistW-1:0] o_dist;

  logic [63:0]        rqx, rqy;
  logic [40:0]        bx, by;
  logic signed [43:0] sx, sy;

  // whole back end advances unless the result register is held
  assign en  = !o_v || res.ready;
  assign pop = en && !job_empty;

  // divider step: shift in one numerator bit, subtract when it fits
  always_comb begin
    for (int j = 1; j <= QuoW; j++) begin
      dv_t[j]  = {dv_rem[j-1], dv_low[j-1][QuoW-1]};
      dv_ge[j] = dv_t[j] >= {1'b0, dv_inf[j-1].den};
    end
  end

  // rounding and saturation of the point coordinates
  always_comb begin
    rqx = a3_px[93:30];
    rqy = a3_py[93:30];
    bx  = (rqx > PtClamp) ? PtClamp[40:0] : rqx[40:0];
    by  = (rqy > PtClamp) ? PtClamp[40:0] : rqy[40:0];
    sx  = a3_xneg ? -$signed({3'b000, bx}) : $signed({3'b000, bx});
    sy  = a3_yneg ? -$signed({3'b000, by}) : $signed({3'b000, by});
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      b0_v <= 1'b0;
      b1_v <= 1'b0;
      b2_v <= 1'b0;
      b3_v <= 1'b0;
      b4_v <= 1'b0;
      for (int j = 0; j <= QuoW; j++) dv_v[j] <= 1'b0;
      a1_v <= 1'b0;
      a2_v <= 1'b0;
      a3_v <= 1'b0;
      o_v  <= 1'b0;
    end else if (en) begin
      b0_v    <= !job_empty;
      b1_v    <= b0_v;
      b2_v    <= b1_v;
      b3_v    <= b2_v;
      b4_v    <= b3_v;
      dv_v[0] <= b4_v;
      for (int j = 1; j <= QuoW; j++) dv_v[j] <= dv_v[j-1];
      a1_v <= dv_v[QuoW];
      a2_v <= a1_v;
      a3_v <= a2_v;
      o_v  <= a3_v;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      b0 <= job;
      // numerator products
      b1_inf <= b0.info;
      b1_p1  <= 66'(b0.vdx) * 66'(b0.dvy);
      b1_p2  <= 66'(b0.vdy) * 66'(b0.dvx);
      b2_inf <= b1_inf;
      b2_num <= 67'(b1_p1) - 67'(b1_p2);
      // magnitude and quotient sign
      b3_inf  <= b2_inf;
      b3_mag  <= b2_num[66] ? 67'(-b2_num) : 67'(b2_num);
      b3_tneg <= b2_num[66] != b2_inf.den_neg;
      // scale by 2^30 and add half the divisor
      b4_inf  <= b3_inf;
      b4_tneg <= b3_tneg;
      b4_m    <= {b3_mag, 30'b0} + 97'(b3_inf.den >> 1);
      // quotient overflow check and divider entry
      dv_inf[0]  <= b4_inf;
      dv_tneg[0] <= b4_tneg;
      dv_ovf[0]  <= {30'b0, b4_m[96:63]} >= b4_inf.den;
      dv_rem[0]  <= {30'b0, b4_m[96:63]};
      dv_low[0]  <= b4_m[62:0];
      dv_q[0]    <= '0;
      for (int j = 1; j <= QuoW; j++) begin
        dv_inf[j]  <= dv_inf[j-1];
        dv_tneg[j] <= dv_tneg[j-1];
        dv_ovf[j]  <= dv_ovf[j-1];
        dv_rem[j]  <= dv_ge[j] ? 64'(dv_t[j] - {1'b0, dv_inf[j-1].den}) : dv_t[j][63:0];
        dv_low[j]  <= {dv_low[j-1][QuoW-2:0], 1'b0};
        dv_q[j]    <= {dv_q[j-1][QuoW-2:0], dv_ge[j]};
      end
      // clamp of the along-line position
      a1_inf  <= dv_inf[QuoW];
      a1_tneg <= dv_tneg[QuoW];
      a1_tmag <= (dv_ovf[QuoW] || dv_q[QuoW] > TClamp) ? TClamp : dv_q[QuoW];
      // direction times position, split in two partial products
      a2_inf  <= a1_inf;
      a2_dist <= (a1_tmag > DistMax) ? '1 : a1_tmag[DistW-1:0];
      a2_xneg <= a1_tneg != cfg.dir_x[31];
      a2_yneg <= a1_tneg != cfg.dir_y[31];
      a2_xl   <= (cfg.dir_x[31] ? 31'(-cfg.dir_x) : 31'(cfg.dir_x)) * a1_tmag[31:0];
      a2_xh   <= (cfg.dir_x[31] ? 31'(-cfg.dir_x) : 31'(cfg.dir_x)) * a1_tmag[62:32];
      a2_yl   <= (cfg.dir_y[31] ? 31'(-cfg.dir_y) : 31'(cfg.dir_y)) * a1_tmag[31:0];
      a2_yh   <= (cfg.dir_y[31] ? 31'(-cfg.dir_y) : 31'(cfg.dir_y)) * a1_tmag[62:32];
      // sum partials with rounding half
      a3_inf  <= a2_inf;
      a3_dist <= a2_dist;
      a3_xneg <= a2_xneg;
      a3_yneg <= a2_yneg;
      a3_px   <= 94'(a2_xl) + {a2_xh, 32'b0} + (94'(1) << 29);
      a3_py   <= 94'(a2_yl) + {a2_yh, 32'b0} + (94'(1) << 29);
      // result register
      o_hit  <= a3_inf.hit;
      o_ss   <= a3_inf.start_side;
      o_es   <= a3_inf.end_side;
      o_dist <= a3_inf.hit ? a3_dist : '0;
      o_x    <= a3_inf.hit ? sat32(44'(cfg.base_x) + sx) : '0;
      o_y    <= a3_inf.hit ? sat32(44'(cfg.base_y) + sy) : '0;
    end
  end

  assign res.valid      = o_v;
  assign res.hit        = o_hit;
  assign res.isect_x    = o_x;
  assign res.isect_y    = o_y;
  assign res.start_side = o_ss;
  assign res.end_side   = o_es;
  assign res.distance   = o_dist;

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (o_v && !o_hit) |-> (o_x == '0 && o_y == '0 && o_dist == '0))
    else $error("missed segment carries a point");
  a_pop_advance: assert property (@(posedge clk) disable iff (rst)
    pop |=> b0_v)
    else $error("popped job not captured");
`endif

endmodule
`default_nettype wire

/* design/general_line_segment_clip_unit.sv */
// Line segment clip unit: reports crossing, sides, intersection point and
// distance of each segment against a configured clip line.
//
// Channels: in_seg (segment endpoints, Q16.16) and out_res (one result per
// segment), valid/ready, a transaction completes when both are high. The clip
// line is set through the apb-style port: base, direction, nudge registers at
// byte addresses 0, 4, ... 20; write only while no segment is in flight.
// Throughput: one segment per cycle while out_res is not stalled. From the
// accepting edge to the result in the output register a segment passes five
// more front stages, one queue write, five numerator stages, one divider
// entry stage, 63 divider stages (one quotient bit each) and four point stages.
// Reset sets the configuration to its defaults (direction along x) and empties
// the pipeline. A stall at out_res freezes the back end; the front keeps
// filling the queue, and in_seg.ready drops once every queue slot is spoken for.
`default_nettype none
module general_line_segment_clip_unit #(
  parameter int FIFO_DEPTH = glsc_pkg::FifoDepthDef
) (
  input  logic                          clk,
  input  logic                          rst,
  glsc_seg_if.sink                      in_seg,
  glsc_res_if.source                    out_res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [glsc_pkg::RegAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import glsc_pkg::*;

  cfg_t                            cfg;
  logic                            job_valid;
  job_t                            job_in, job_out;
  logic                            pop, empty;
  logic [$clog2(FIFO_DEPTH+1)-1:0] cnt;

  glsc_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg(cfg)
  );

  glsc_front #(.DEPTH(FIFO_DEPTH)) u_front (
    .clk, .rst, .seg(in_seg), .cfg(cfg), .fifo_cnt(cnt),
    .job_valid(job_valid), .job(job_in)
  );

  glsc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk, .rst, .wr(job_valid), .wdata(job_in), .rd(pop), .rdata(job_out),
    .empty(empty), .cnt(cnt)
  );

  glsc_back u_back (
    .clk, .rst, .job_empty(empty), .job(job_out), .pop(pop), .cfg(cfg),
    .res(out_res)
  );

endmodule
`default_nettype wire
